>>> sv/rdq_pkg.sv
// rdq_pkg: shared op codes, command types and back-end state for reversible_deque.
// No dependencies.
package rdq_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned OpW   = 3;

  localparam logic [OpW-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH    = 3'd1;
  localparam logic [OpW-1:0] OP_REVERSE = 3'd2;
  localparam logic [OpW-1:0] OP_POP     = 3'd3;
  localparam logic [OpW-1:0] OP_DUMP    = 3'd4;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_PUSH,
    CMD_REVERSE,
    CMD_POP,
    CMD_DUMP
  } cmd_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [WordW-1:0] value;
  } cmd_t;

  typedef enum logic {
    BK_RUN,
    BK_DUMP
  } bk_state_e;

endpackage

>>> sv/rdq_front.sv
// rdq_front: accepts input requests and classifies the op code into a command.
// Depends on rdq_pkg.
module rdq_front (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  op_i,
  input  logic signed [31:0]          value_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output rdq_pkg::cmd_t               q_data_o
);
  import rdq_pkg::*;

  cmd_e cmd;

  always_comb begin
    case (op_i)
      OP_CLEAR:   cmd = CMD_CLEAR;
      OP_PUSH:    cmd = CMD_PUSH;
      OP_REVERSE: cmd = CMD_REVERSE;
      OP_POP:     cmd = CMD_POP;
      OP_DUMP:    cmd = CMD_DUMP;
      default:    cmd = CMD_NOP;
    endcase
  end

  assign in_stall_o     = q_full_i;
  assign q_push_o       = in_valid_i && !q_full_i;
  assign q_data_o.cmd   = cmd;
  assign q_data_o.value = value_i;

endmodule

>>> sv/rdq_fifo.sv
// rdq_fifo: two-entry command queue between front and back.
// Depends on rdq_pkg.
module rdq_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rdq_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output rdq_pkg::cmd_t data_o
);
  import rdq_pkg::*;

  cmd_t       slots_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign data_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> sv/rdq_back.sv
// rdq_back: executes commands against the circular store, sequences dumps and
// holds the result register. Depends on rdq_pkg.
module rdq_back #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  rdq_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] element_o,
  output logic               has_element_o,
  output logic               is_empty_o,
  output logic               error_o,
  output logic               overflow_o,
  output logic               last_o
);
  import rdq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [WordW-1:0] mem [DEPTH];
  logic [WordW-1:0] rd_data_q;

  bk_state_e     state_q, state_d;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rev_q, rev_d;
  logic          err_q, err_d;

  logic          out_valid_q;
  logic [WordW-1:0] elem_q, elem_d;
  logic          has_q, has_d;
  logic          empty_q, empty_d;
  logic          oerr_q, oerr_d;
  logic          ovf_q, ovf_d;
  logic          last_q, last_d;
  logic          out_load;

  logic          out_free, cmd_take, dump_last;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [CW-1:0] rd_off;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign cmd_take  = (state_q == BK_RUN) && cmd_valid_i && out_free;
  assign cmd_pop_o = cmd_take;
  assign dump_last = idx_q == (count_q - CW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_RUN: begin
        if (cmd_take && cmd_i.cmd == CMD_DUMP && count_q != '0) begin
          state_d = BK_DUMP;
        end
      end
      BK_DUMP: begin
        if (out_free && dump_last) begin
          state_d = BK_RUN;
        end
      end
      default: state_d = BK_RUN;
    endcase
  end

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    idx_d    = idx_q;
    rev_d    = rev_q;
    err_d    = err_q;
    wr_en    = 1'b0;
    out_load = 1'b0;
    elem_d   = '0;
    has_d    = 1'b0;
    empty_d  = 1'b1;
    oerr_d   = err_q;
    ovf_d    = 1'b0;
    last_d   = 1'b1;
    case (state_q)
      BK_RUN: begin
        if (cmd_take) begin
          out_load = 1'b1;
          case (cmd_i.cmd)
            CMD_CLEAR: begin
              front_d = '0;
              count_d = '0;
              rev_d   = 1'b0;
              err_d   = 1'b0;
            end
            CMD_PUSH: begin
              if (count_q == CW'(DEPTH)) begin
                ovf_d = 1'b1;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            CMD_REVERSE: rev_d = !rev_q;
            CMD_POP: begin
              if (count_q == '0) begin
                err_d = 1'b1;
              end else begin
                if (!rev_q) begin
                  front_d = slot_of(front_q, CW'(1));
                end
                count_d = count_q - CW'(1);
              end
            end
            CMD_DUMP: begin
              if (count_q != '0) begin
                out_load = 1'b0;
                idx_d    = '0;
              end
            end
            default: ;
          endcase
          empty_d = count_d == '0;
          oerr_d  = err_d;
        end
      end
      BK_DUMP: begin
        if (out_free) begin
          out_load = 1'b1;
          elem_d   = rd_data_q;
          has_d    = 1'b1;
          empty_d  = 1'b0;
          last_d   = dump_last;
          idx_d    = idx_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // read address tracks the next dump index so data lands in the following cycle
  assign rd_off  = rev_q ? (count_q - CW'(1) - idx_d) : idx_d;
  assign rd_addr = slot_of(front_q, rd_off);
  assign wr_addr = slot_of(front_q, count_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.value;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      rev_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      rev_q   <= rev_d;
      err_q   <= err_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      elem_q  <= elem_d;
      has_q   <= has_d;
      empty_q <= empty_d;
      oerr_q  <= oerr_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign element_o     = elem_q;
  assign has_element_o = has_q;
  assign is_empty_o    = empty_q;
  assign error_o       = oerr_q;
  assign overflow_o    = ovf_q;
  assign last_o        = last_q;

endmodule

>>> sv/reversible_deque.sv
// reversible_deque: bounded deque of signed words with a direction bit.
// Depends on rdq_pkg, rdq_front, rdq_fifo, rdq_back.
//
//   channel   signals                                  dir
//   in        in_valid_i, in_stall_o, op_i, value_i    request in
//   out       out_valid_o, out_stall_i, element_o,     result out
//             has_element_o, is_empty_o, error_o,
//             overflow_o, last_o
//
// Clear, push, reverse, pop and unknown ops: one status result each from the back end.
// Dump: the store read starts first, then one result per stored element (empty: one status result).
// A two-entry command queue lets requests enter while the back end dumps.
// Reset clears pointers, count and flags; store contents stay undefined.
// A stalled result holds in the output register and stalls the back end.
module reversible_deque #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] element_o,
  output logic               has_element_o,
  output logic               is_empty_o,
  output logic               error_o,
  output logic               overflow_o,
  output logic               last_o
);
  import rdq_pkg::*;

  cmd_t q_in, q_out;
  logic q_push, q_full, q_valid, q_pop;

  rdq_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  rdq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_out)
  );

  rdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_out),
    .cmd_pop_o     (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .element_o     (element_o),
    .has_element_o (has_element_o),
    .is_empty_o    (is_empty_o),
    .error_o       (error_o),
    .overflow_o    (overflow_o),
    .last_o        (last_o)
  );

endmodule

>>> sv/rdq_checker.sv
// rdq_checker: port-level checks for reversible_deque, bound to the top level.
// Depends on reversible_deque ports only.
module rdq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] element_o,
  input logic               has_element_o,
  input logic               is_empty_o,
  input logic               overflow_o,
  input logic               last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(element_o) && $stable(last_o))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_element_o |-> element_o == 32'sd0 && last_o)
    else $error("status result malformed");

  a_elem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_element_o |-> !is_empty_o && !overflow_o)
    else $error("dump result with bad status");

  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> !is_empty_o)
    else $error("overflow on empty deque");

endmodule

bind reversible_deque rdq_checker u_rdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .element_o     (element_o),
  .has_element_o (has_element_o),
  .is_empty_o    (is_empty_o),
  .overflow_o    (overflow_o),
  .last_o        (last_o)
);

>>> verif/tb_top.sv
// tb_top: self-checking testbench for reversible_deque, driven with directed then random requests.
// Depends on rdq_pkg and reversible_deque. Results are checked against an in-bench deque model
// with random idling on both channels.
`timescale 1ns / 100ps

module tb_top;
  import rdq_pkg::*;

  localparam int unsigned DEPTH      = 64;
  localparam int          N_RANDOM   = 480;
  localparam int          MAX_GAP    = 18;
  localparam int          HOLD_LEN   = 400;
  localparam int          IDLE_LIMIT = 3000;
  localparam int          DRAIN_LEN  = 100;
  localparam int          MAX_REPORT = 10;

  localparam logic [OpW-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OpW-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OpW-1:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic signed [31:0] element;
    logic               has_element;
    logic               is_empty;
    logic               error;
    logic               overflow;
    logic               last;
  } dq_result_t;

  // typed rows carry a plain status result: element 0, no overflow, last set
  typedef struct packed {
    logic [OpW-1:0]     op;
    logic signed [31:0] value;
    bit                 typed;
    bit                 empty;
    bit                 err;
  } req_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         op_i = OP_CLEAR;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  logic signed [31:0] element_o;
  logic               has_element_o;
  logic               is_empty_o;
  logic               error_o;
  logic               overflow_o;
  logic               last_o;

  reversible_deque #(.DEPTH(DEPTH)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .element_o     (element_o),
    .has_element_o (has_element_o),
    .is_empty_o    (is_empty_o),
    .error_o       (error_o),
    .overflow_o    (overflow_o),
    .last_o        (last_o)
  );

  req_row_t directed_rows [25] = '{
    '{OP_POP,     32'sd0,           1'b1, 1'b1, 1'b1},
    '{OP_DUMP,    32'sd0,           1'b1, 1'b1, 1'b1},
    '{OP_RSVD5,   32'sd0,           1'b1, 1'b1, 1'b1},
    '{OP_CLEAR,   32'sd0,           1'b1, 1'b1, 1'b0},
    '{OP_PUSH,    32'sh7fffffff,    1'b1, 1'b0, 1'b0},
    '{OP_PUSH,    32'sh80000000,    1'b1, 1'b0, 1'b0},
    '{OP_PUSH,    -32'sd1,          1'b0, 1'b0, 1'b0},
    '{OP_PUSH,    32'sd0,           1'b0, 1'b0, 1'b0},
    '{OP_DUMP,    32'sd0,           1'b0, 1'b0, 1'b0},
    '{OP_REVERSE, 32'sd0,           1'b1, 1'b0, 1'b0},
    '{OP_DUMP,    32'sd0,           1'b0, 1'b0, 1'b0},
    '{OP_POP,     32'sd0,           1'b0, 1'b0, 1'b0},
    '{OP_DUMP,    32'sd0,           1'b0, 1'b0, 1'b0},
    '{OP_REVERSE, 32'sd0,           1'b1, 1'b0, 1'b0},
    '{OP_POP,     32'sd0,           1'b0, 1'b0, 1'b0},
    '{OP_DUMP,    32'sd0,           1'b0, 1'b0, 1'b0},
    '{OP_RSVD6,   32'sd0,           1'b1, 1'b0, 1'b0},
    '{OP_PUSH,    32'sh5a5a5a5a,    1'b0, 1'b0, 1'b0},
    '{OP_POP,     32'sd0,           1'b0, 1'b0, 1'b0},
    '{OP_POP,     32'sd0,           1'b0, 1'b0, 1'b0},
    '{OP_POP,     32'sd0,           1'b0, 1'b0, 1'b0},
    '{OP_POP,     32'sd0,           1'b1, 1'b1, 1'b1},
    '{OP_RSVD7,   32'sd0,           1'b1, 1'b1, 1'b1},
    '{OP_DUMP,    32'sd0,           1'b0, 1'b0, 1'b0},
    '{OP_CLEAR,   32'sd0,           1'b1, 1'b1, 1'b0}
  };

  // deque model
  logic signed [31:0] dq_mem [DEPTH];
  logic [5:0]         dq_front;
  int                 dq_count;
  bit                 dq_rev;
  bit                 dq_err;

  dq_result_t pending_q [$];

  int  fails;
  int  n_req;
  int  n_res;
  int  n_ovf;
  int  n_dump_elems;
  int  idle_cycles;
  bit  hold_rx;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic dq_result_t status_of(bit ovf);
    dq_result_t r;
    r.element     = '0;
    r.has_element = 1'b0;
    r.is_empty    = (dq_count == 0);
    r.error       = dq_err;
    r.overflow    = ovf;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic void advance_deque(logic [OpW-1:0] op, logic signed [31:0] val,
                                        bit queue_it);
    bit         ovf;
    int         off;
    dq_result_t r;
    ovf = 1'b0;
    case (op)
      OP_CLEAR: begin
        dq_front = '0;
        dq_count = 0;
        dq_rev   = 1'b0;
        dq_err   = 1'b0;
      end
      OP_PUSH: begin
        if (dq_count >= DEPTH) begin
          ovf = 1'b1;
          n_ovf++;
        end else begin
          dq_mem[6'(dq_front + 6'(dq_count))] = val;
          dq_count++;
        end
      end
      OP_REVERSE: dq_rev = !dq_rev;
      OP_POP: begin
        if (dq_count == 0) begin
          dq_err = 1'b1;
        end else begin
          if (!dq_rev) dq_front = dq_front + 6'd1;
          dq_count--;
        end
      end
      OP_DUMP: begin
        if (dq_count != 0) begin
          for (int i = 0; i < dq_count; i++) begin
            off           = dq_rev ? (dq_count - 1 - i) : i;
            r             = status_of(1'b0);
            r.element     = dq_mem[6'(dq_front + 6'(off))];
            r.has_element = 1'b1;
            r.last        = (i + 1 == dq_count);
            if (queue_it) pending_q.push_back(r);
          end
          n_dump_elems += dq_count;
          return;
        end
      end
      default: ;
    endcase
    if (queue_it) pending_q.push_back(status_of(ovf));
  endfunction

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic send_req(logic [OpW-1:0] op, logic signed [31:0] val, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= val;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    n_req++;
  endtask

  task automatic issue(logic [OpW-1:0] op, logic signed [31:0] val, bit calm);
    send_req(op, val, draw_gap(calm || ((n_req / 40) % 4 == 3)));
    advance_deque(op, val, 1'b1);
  endtask

  // fill to capacity, overflow, dump, maybe reverse, then pop past empty
  task automatic fill_and_drain(bit squeeze);
    int extra;
    extra = $urandom_range(1, 3);
    if (squeeze) hold_rx = 1'b1;
    while (dq_count < DEPTH) issue(OP_PUSH, $urandom, squeeze);
    repeat (extra) issue(OP_PUSH, $urandom, squeeze);
    issue(OP_DUMP, $urandom, squeeze);
    if ($urandom_range(0, 1)) issue(OP_REVERSE, $urandom, squeeze);
    while (dq_count > 0) issue(OP_POP, $urandom, squeeze);
    issue(OP_POP, $urandom, squeeze);
  endtask

  initial begin
    int          start;
    int          sel;
    logic [OpW-1:0] rsvd;
    dq_front = '0;
    dq_count = 0;
    dq_rev   = 1'b0;
    dq_err   = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      send_req(directed_rows[k].op, directed_rows[k].value, draw_gap(1'b0));
      advance_deque(directed_rows[k].op, directed_rows[k].value, !directed_rows[k].typed);
      if (directed_rows[k].typed) begin
        pending_q.push_back('{element: '0, has_element: 1'b0,
                              is_empty: directed_rows[k].empty,
                              error: directed_rows[k].err,
                              overflow: 1'b0, last: 1'b1});
      end
    end

    start = n_req;
    fill_and_drain(1'b1);
    while (n_req - start < N_RANDOM) begin
      if (n_req - start > N_RANDOM / 2 && n_ovf < 4) fill_and_drain(1'b0);
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        issue(OP_PUSH, $urandom, 1'b0);
      end else if (sel < 62) begin
        issue(OP_POP, $urandom, 1'b0);
      end else if (sel < 70) begin
        issue(OP_REVERSE, $urandom, 1'b0);
      end else if (sel < 80) begin
        issue(OP_DUMP, $urandom, 1'b0);
      end else if (sel < 85) begin
        issue(OP_CLEAR, $urandom, 1'b0);
      end else if (sel < 90) begin
        rsvd = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        issue(rsvd, $urandom, 1'b0);
      end else begin
        case ($urandom_range(0, 3))
          0: issue(OP_PUSH, 32'sh7fffffff, 1'b0);
          1: issue(OP_PUSH, 32'sh80000000, 1'b0);
          2: issue(OP_PUSH, -32'sd1, 1'b0);
          default: issue(OP_PUSH, 32'sd0, 1'b0);
        endcase
      end
    end
    in_valid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_LEN) @(posedge clk_i);

    $display("%0d requests sent, %0d results checked, %0d dumped elements",
             n_req, n_res, n_dump_elems);
    $display("%0d dropped pushes at full depth, %0d failures", n_ovf, fails);
    if (fails == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // result side: random stall per result, one long hold-off on request
  initial begin
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        n = HOLD_LEN;
      end else begin
        n = draw_gap((n_res / 50) % 4 == 2);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(negedge clk_i); while (!out_valid_o);
      @(posedge clk_i);
    end
  end

  always @(negedge clk_i) begin
    dq_result_t got;
    dq_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{element: element_o, has_element: has_element_o, is_empty: is_empty_o,
              error: error_o, overflow: overflow_o, last: last_o};
      n_res++;
      if (pending_q.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORT) begin
          $display("%0t: unexpected result element=%h has=%b empty=%b err=%b ovf=%b last=%b",
                   $realtime, got.element, got.has_element, got.is_empty, got.error,
                   got.overflow, got.last);
        end
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= MAX_REPORT) begin
            $display("%0t: result %0d mismatch", $realtime, n_res);
            $display("  expected element=%h has=%b empty=%b err=%b ovf=%b last=%b",
                     want.element, want.has_element, want.is_empty, want.error,
                     want.overflow, want.last);
            $display("  actual   element=%h has=%b empty=%b err=%b ovf=%b last=%b",
                     got.element, got.has_element, got.is_empty, got.error,
                     got.overflow, got.last);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $realtime, idle_cycles, pending_q.size());
        $display("tb_top failed");
        $finish;
      end
    end
  end

endmodule

>>> sim.f
sv/rdq_pkg.sv
sv/rdq_front.sv
sv/rdq_fifo.sv
sv/rdq_back.sv
sv/reversible_deque.sv
sv/rdq_checker.sv
verif/tb_top.sv
